// ===== sv/sobol3d_pkg.sv =====
// Package for the 3-D Sobol point generator: beat types, command codes and
// the constant direction-word table. No dependencies.
`timescale 1ns / 1ps

package sobol3d_pkg;

  localparam int unsigned CoordW   = 32;
  localparam int unsigned DirCount = 32;
  localparam int unsigned DimCount = 3;
  localparam int unsigned DirSelW  = $clog2(DirCount);

  typedef enum logic {
    CMD_NEXT = 1'b0,
    CMD_SEEK = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t              command;
    logic [CoordW-1:0] seek_index;
  } in_beat_t;

  typedef struct packed {
    logic [CoordW-1:0] coord_x;
    logic [CoordW-1:0] coord_y;
    logic [CoordW-1:0] coord_z;
  } out_beat_t;

  typedef logic [DimCount-1:0][CoordW-1:0] coord_set_t;
  typedef logic [DimCount-1:0][DirCount-1:0][CoordW-1:0] dir_tbl_t;

  // Stage-one state shared between the input register and the top level.
  typedef struct packed {
    logic     valid;
    in_beat_t beat;
  } stage_t;

  // Direction words, each aligned to bit 31.
  function automatic dir_tbl_t build_dirs();
    dir_tbl_t t;
    t = '0;
    for (int j = 0; j < DirCount; j++) begin
      t[0][j] = 32'h8000_0000 >> j;
    end
    t[1][0] = 32'h8000_0000;
    for (int j = 1; j < DirCount; j++) begin
      t[1][j] = t[1][j-1] ^ (t[1][j-1] >> 1);
    end
    t[2][0] = 32'h8000_0000;
    t[2][1] = 32'hC000_0000;
    for (int j = 2; j < DirCount; j++) begin
      t[2][j] = t[2][j-2] ^ (t[2][j-2] >> 2) ^ t[2][j-1];
    end
    return t;
  endfunction

  localparam dir_tbl_t DIR_TBL = build_dirs();

endpackage

// ===== sv/sobol3d_in_reg.sv =====
// Input register stage of the 3-D Sobol generator.
// Depends on sobol3d_pkg for the beat and stage types.
`timescale 1ns / 1ps

module sobol3d_in_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  sobol3d_pkg::in_beat_t in_data,
  input  logic                go,
  output sobol3d_pkg::stage_t st
);

  logic                   valid_r;
  logic                   valid_nxt;
  sobol3d_pkg::in_beat_t  beat_r;
  logic                   load;

  // The stage frees up in the same cycle its beat moves on.
  assign in_stall  = valid_r & ~go;
  assign load      = in_valid & ~in_stall;
  assign valid_nxt = load | (valid_r & ~go);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      beat_r <= in_data;
    end
  end

  assign st.valid = valid_r;
  assign st.beat  = beat_r;

endmodule

// ===== sv/sobol3d_step.sv =====
// Next-state logic of the 3-D Sobol generator: Gray-code step and seek load.
// Depends on sobol3d_pkg for the direction table and types.
`timescale 1ns / 1ps

module sobol3d_step #(
  parameter int unsigned WORD_BITS = 32
) (
  input  sobol3d_pkg::in_beat_t     beat,
  input  logic [WORD_BITS-1:0]      idx,
  input  sobol3d_pkg::coord_set_t   coords,
  output logic [WORD_BITS-1:0]      idx_nxt,
  output sobol3d_pkg::coord_set_t   coords_nxt,
  output sobol3d_pkg::coord_set_t   point
);

  localparam int unsigned IdxW = $clog2(WORD_BITS);

  logic [IdxW-1:0]                    tz;
  logic [sobol3d_pkg::DirSelW-1:0]    dir_sel;
  logic [WORD_BITS-1:0]               inc;
  logic [WORD_BITS-1:0]               seek_idx;
  logic [WORD_BITS-1:0]               seek_prev;
  logic [WORD_BITS-1:0]               gray;
  sobol3d_pkg::coord_set_t            stepped;
  sobol3d_pkg::coord_set_t            seeked;

  // Trailing-zero count; the index is never zero here.
  always_comb begin
    tz = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (idx[i]) begin
        tz = IdxW'(i);
      end
    end
  end

  assign dir_sel = sobol3d_pkg::DirSelW'(tz);
  assign inc     = idx + WORD_BITS'(1);

  always_comb begin
    for (int d = 0; d < sobol3d_pkg::DimCount; d++) begin
      stepped[d] = coords[d] ^ sobol3d_pkg::DIR_TBL[d][dir_sel];
    end
  end

  // Seek: coordinates are the XOR of the directions picked by gray(idx-1).
  assign seek_idx  = (beat.seek_index[WORD_BITS-1:0] == '0) ? WORD_BITS'(1)
                                                          : beat.seek_index[WORD_BITS-1:0];
  assign seek_prev = seek_idx - WORD_BITS'(1);
  assign gray      = seek_prev ^ (seek_prev >> 1);

  always_comb begin
    seeked = '0;
    for (int d = 0; d < sobol3d_pkg::DimCount; d++) begin
      for (int k = 0; k < WORD_BITS; k++) begin
        if (gray[k]) begin
          seeked[d] = seeked[d] ^ sobol3d_pkg::DIR_TBL[d][k];
        end
      end
    end
  end

  always_comb begin
    point = stepped;
    if (beat.command == sobol3d_pkg::CMD_SEEK) begin
      idx_nxt    = seek_idx;
      coords_nxt = seeked;
    end else if (inc == '0) begin
      // Index wrap restarts the sequence at its first point.
      idx_nxt    = WORD_BITS'(1);
      coords_nxt = '0;
    end else begin
      idx_nxt    = inc;
      coords_nxt = stepped;
    end
  end

endmodule

// ===== sv/sobol3d_out_reg.sv =====
// Output register stage of the 3-D Sobol generator.
// Depends on sobol3d_pkg for the result beat type.
`timescale 1ns / 1ps

module sobol3d_out_reg (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load,
  input  sobol3d_pkg::out_beat_t beat,
  output logic                   free,
  output logic                   out_valid,
  input  logic                   out_stall,
  output sobol3d_pkg::out_beat_t out_data
);

  logic                   valid_r;
  logic                   valid_nxt;
  sobol3d_pkg::out_beat_t data_r;

  // The register can take a new beat when empty or being drained.
  assign free      = ~valid_r | ~out_stall;
  assign valid_nxt = load | (valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= beat;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// ===== sv/sobol_point_generator_3d.sv =====
// A next beat is first registered in stage one; when it moves on, its point
// is registered in the output register, which presents it on out_data.
// Throughput: one beat per cycle, next and seek alike, limited only by stalls.
// A seek beat produces no result and passes even while the output is stalled.
// Reset (rst_n low at a clock edge) sets the point index to 1, clears the
// three coordinates and empties both register stages.
`timescale 1ns / 1ps

module sobol_point_generator_3d #(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  sobol3d_pkg::in_beat_t  in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output sobol3d_pkg::out_beat_t out_data
);

  // Stage one holds the accepted beat. The generator state (index and
  // coordinates) is updated when that beat moves on, so consecutive beats
  // see each other's effect without any bubble.
  sobol3d_pkg::stage_t      st;
  logic                     go;
  logic                     out_free;
  logic                     is_seek;

  logic [WORD_BITS-1:0]     idx_r;
  logic [WORD_BITS-1:0]     idx_nxt;
  sobol3d_pkg::coord_set_t  coords_r;
  sobol3d_pkg::coord_set_t  coords_nxt;
  sobol3d_pkg::coord_set_t  point;
  sobol3d_pkg::out_beat_t   res_beat;

  sobol3d_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .go       (go),
    .st       (st)
  );

  // A seek only touches the state; a next also needs room in the output
  // register for the point it emits.
  assign is_seek = (st.beat.command == sobol3d_pkg::CMD_SEEK);
  assign go      = st.valid & (is_seek | out_free);

  sobol3d_step #(
    .WORD_BITS (WORD_BITS)
  ) u_step (
    .beat       (st.beat),
    .idx        (idx_r),
    .coords     (coords_r),
    .idx_nxt    (idx_nxt),
    .coords_nxt (coords_nxt),
    .point      (point)
  );

  // Generator state: the index never takes the value zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r    <= WORD_BITS'(1);
      coords_r <= '0;
    end else if (go) begin
      idx_r    <= idx_nxt;
      coords_r <= coords_nxt;
    end
  end

  assign res_beat.coord_x = point[0];
  assign res_beat.coord_y = point[1];
  assign res_beat.coord_z = point[2];

  sobol3d_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (go & ~is_seek),
    .beat      (res_beat),
    .free      (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // The point index is kept away from zero by reset, seek and wrap handling.
  a_idx_nonzero : assert property (@(posedge clk) disable iff (!rst_n)
    idx_r != '0)
    else $error("point index reached zero");

  // A next beat that moves on always lands in the output register.
  a_next_emits : assert property (@(posedge clk) disable iff (!rst_n)
    (go && !is_seek) |=> out_valid)
    else $error("next beat produced no result");

  // A seek beat never creates a result of its own.
  a_seek_silent : assert property (@(posedge clk) disable iff (!rst_n)
    (go && is_seek) |=> (out_valid == $past(out_valid && out_stall)))
    else $error("seek beat produced a result");

  // Input is held off only while stage one is occupied and blocked.
  a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (st.valid && !is_seek && out_valid && out_stall))
    else $error("input stalled without cause");

endmodule
